// ===== hdl/ubxd_pkg.sv =====
package ubxd_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	// configuration register indexes
	localparam logic [1:0] CFG_CLASS  = 2'd0;
	localparam logic [1:0] CFG_ID     = 2'd1;
	localparam logic [1:0] CFG_LENGTH = 2'd2;

	localparam logic [7:0]  SEL_CLASS_RST  = 8'd1;
	localparam logic [7:0]  SEL_ID_RST     = 8'd7;
	localparam logic [15:0] SEL_LENGTH_RST = 16'd92;

	// frame status codes
	localparam logic [2:0] ST_SEL_OK    = 3'd0;
	localparam logic [2:0] ST_OTHER_OK  = 3'd1;
	localparam logic [2:0] ST_CK_BAD    = 3'd2;
	localparam logic [2:0] ST_SEL_LEN   = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	typedef struct packed {
		logic [7:0]  select_class;
		logic [7:0]  select_id;
		logic [15:0] select_length;
	} sel_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        frame_end;
		logic [2:0]  frame_status;
		logic [7:0]  message_class;
		logic [7:0]  msg_id;
		logic [15:0] payload_length;
	} res_t;

endpackage

// ===== hdl/ubxd_if.sv =====
interface ubxd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface ubxd_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        byte_valid;
	logic        frame_end;
	logic [2:0]  frame_status;
	logic [7:0]  message_class;
	logic [7:0]  msg_id;
	logic [15:0] payload_length;

	modport source(output valid, output payload_byte, output byte_valid, output frame_end,
		output frame_status, output message_class, output msg_id,
		output payload_length, input ready);
	modport sink(input valid, input payload_byte, input byte_valid, input frame_end,
		input frame_status, input message_class, input msg_id,
		input payload_length, output ready);
endinterface

// ===== hdl/ubxd_parser.sv =====
module ubxd_parser #(
	parameter int MAX_PAYLOAD_LEN = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  ubxd_pkg::sel_t  sel,
	input  logic            slot_free,
	output logic            push,
	output ubxd_pkg::res_t  res
);

	localparam logic [3:0] PH_HUNT1   = 4'd0;
	localparam logic [3:0] PH_HUNT2   = 4'd1;
	localparam logic [3:0] PH_CLASS   = 4'd2;
	localparam logic [3:0] PH_ID      = 4'd3;
	localparam logic [3:0] PH_LEN_LO  = 4'd4;
	localparam logic [3:0] PH_LEN_HI  = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_CK_A    = 4'd7;
	localparam logic [3:0] PH_CK_B    = 4'd8;

	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD_LEN);

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic [3:0]  phase_q, phase_n;
	logic [7:0]  sum_a_q, sum_b_q, sum_a_n, sum_b_n;
	logic [15:0] len_q, len_n, left_q, left_n;
	logic [7:0]  class_q, class_n, id_q, id_n, cka_q, cka_n;

	logic [15:0] len_full;
	logic        too_long;
	logic        has_res;
	logic        take;
	logic        sum_en;
	logic [7:0]  sum_a_base, sum_b_base;

	assign len_full  = {byte_s1, len_q[7:0]};
	assign too_long  = len_full > MAX_LEN;
	assign has_res   = (phase_q == PH_LEN_HI && too_long) || phase_q == PH_PAYLOAD
		|| phase_q == PH_CK_B;
	assign take      = valid_s1 && (!has_res || slot_free);
	assign in_ready  = !valid_s1 || take;
	assign push      = take && has_res;

	// fletcher pair restarts on the class byte
	assign sum_a_base = (phase_q == PH_CLASS) ? 8'd0 : sum_a_q;
	assign sum_b_base = (phase_q == PH_CLASS) ? 8'd0 : sum_b_q;
	assign sum_a_n    = sum_a_base + byte_s1;
	assign sum_b_n    = sum_b_base + sum_a_n;

	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		left_n  = left_q;
		class_n = class_q;
		id_n    = id_q;
		cka_n   = cka_q;
		sum_en  = 1'b0;
		res     = '0;
		res.message_class  = class_q;
		res.msg_id         = id_q;
		res.payload_length = len_q;
		case (phase_q)
			PH_HUNT2: begin
				if (byte_s1 == ubxd_pkg::SYNC_SECOND) begin
					phase_n = PH_CLASS;
				end else if (byte_s1 != ubxd_pkg::SYNC_FIRST) begin
					phase_n = PH_HUNT1;
				end
			end
			PH_CLASS: begin
				sum_en  = 1'b1;
				class_n = byte_s1;
				phase_n = PH_ID;
			end
			PH_ID: begin
				sum_en  = 1'b1;
				id_n    = byte_s1;
				phase_n = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				sum_en  = 1'b1;
				len_n   = {8'd0, byte_s1};
				phase_n = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				sum_en  = 1'b1;
				len_n   = len_full;
				left_n  = len_full;
				res.payload_length = len_full;
				if (too_long) begin
					phase_n          = PH_HUNT1;
					res.frame_end    = 1'b1;
					res.frame_status = ubxd_pkg::ST_TOO_LONG;
				end else if (len_full == 16'd0) begin
					phase_n = PH_CK_A;
				end else begin
					phase_n = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				sum_en  = 1'b1;
				left_n  = left_q - 16'd1;
				if (left_q == 16'd1) begin
					phase_n = PH_CK_A;
				end
				res.payload_byte = byte_s1;
				res.byte_valid   = 1'b1;
			end
			PH_CK_A: begin
				cka_n   = byte_s1;
				phase_n = PH_CK_B;
			end
			PH_CK_B: begin
				phase_n       = PH_HUNT1;
				res.frame_end = 1'b1;
				if (cka_q != sum_a_q || byte_s1 != sum_b_q) begin
					res.frame_status = ubxd_pkg::ST_CK_BAD;
				end else if (class_q == sel.select_class && id_q == sel.select_id) begin
					res.frame_status = (len_q == sel.select_length) ?
						ubxd_pkg::ST_SEL_OK : ubxd_pkg::ST_SEL_LEN;
				end else begin
					res.frame_status = ubxd_pkg::ST_OTHER_OK;
				end
			end
			default: begin
				phase_n = (byte_s1 == ubxd_pkg::SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			sum_a_q <= 8'd0;
			sum_b_q <= 8'd0;
			len_q   <= 16'd0;
			left_q  <= 16'd0;
			class_q <= 8'd0;
			id_q    <= 8'd0;
			cka_q   <= 8'd0;
		end else if (take) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			left_q  <= left_n;
			class_q <= class_n;
			id_q    <= id_n;
			cka_q   <= cka_n;
			if (sum_en) begin
				sum_a_q <= sum_a_n;
				sum_b_q <= sum_b_n;
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> slot_free)
		else $error("result pushed into a full output register");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(res.byte_valid && res.frame_end))
		else $error("result is both payload word and frame end");

	a_ckb_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_CK_B) |=> phase_q == PH_HUNT1)
		else $error("parser did not return to sync hunt after frame");

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != 16'd0)
		else $error("payload phase with no bytes left");

endmodule

// ===== hdl/ubxd_out_reg.sv =====
module ubxd_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ubxd_pkg::res_t  res,
	output logic            slot_free,
	ubxd_res_if.source      out
);

	logic           valid_q;
	ubxd_pkg::res_t res_q;

	assign slot_free = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && push) begin
			res_q <= res;
		end
	end

	assign out.valid          = valid_q;
	assign out.payload_byte   = res_q.payload_byte;
	assign out.byte_valid     = res_q.byte_valid;
	assign out.frame_end      = res_q.frame_end;
	assign out.frame_status   = res_q.frame_status;
	assign out.message_class  = res_q.message_class;
	assign out.msg_id         = res_q.msg_id;
	assign out.payload_length = res_q.payload_length;

endmodule

// ===== hdl/ubx_frame_deframer.sv =====
// an accepted byte is registered in the parser input stage; its word is then registered in the output register
// throughput: one byte per cycle while the output register has room, set by the parse state update
// sync, header and first checksum bytes give no word; a payload byte, the second
// checksum byte or an over-long length field each give one
// reset (arst_n low) returns to sync hunt, clears sums and drops any pending word;
// select registers come back as class 1, id 7, length 92
module ubx_frame_deframer #(
	parameter int MAX_PAYLOAD_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	ubxd_rx_if.sink     rx,
	ubxd_res_if.source  res
);

	ubxd_pkg::sel_t sel_q;
	ubxd_pkg::res_t res_n;
	logic           push;
	logic           slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q.select_class  <= ubxd_pkg::SEL_CLASS_RST;
			sel_q.select_id     <= ubxd_pkg::SEL_ID_RST;
			sel_q.select_length <= ubxd_pkg::SEL_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ubxd_pkg::CFG_CLASS:  sel_q.select_class  <= cfg_data[7:0];
				ubxd_pkg::CFG_ID:     sel_q.select_id     <= cfg_data[7:0];
				ubxd_pkg::CFG_LENGTH: sel_q.select_length <= cfg_data;
				default: ;
			endcase
		end
	end

	ubxd_parser #(
		.MAX_PAYLOAD_LEN(MAX_PAYLOAD_LEN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.in_byte   (rx.rx_byte),
		.sel       (sel_q),
		.slot_free (slot_free),
		.push      (push),
		.res       (res_n)
	);

	ubxd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res_n),
		.slot_free (slot_free),
		.out       (res)
	);

endmodule
